/* hw/rtl/residual_running_mean_histogram_macros.svh */
// Assertion macros for the residual running mean histogram block.
// Included by the top level; no other dependencies.
`ifndef RESIDUAL_RUNNING_MEAN_HISTOGRAM_MACROS_SVH
`define RESIDUAL_RUNNING_MEAN_HISTOGRAM_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRMH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rrmh_pkg.sv */
// Shared constants for the residual running mean histogram block.
// No dependencies.
package rrmh_pkg;

    localparam int ELEMENTS_DEF = 1024;
    localparam int BINS_DEF     = 100;

    localparam logic [31:0] HIST_MIN_RST   = 32'hFFFB_0000;  // -5.0
    localparam logic [30:0] HIST_SCALE_RST = 31'd655360;     // 10.0

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic REG_HIST_MIN   = 1'b0;
    localparam logic REG_HIST_SCALE = 1'b1;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

endpackage

/* hw/rtl/residual_running_mean_histogram.sv */
// Top level: per-element running means and histogram of residuals.
// Uses rrmh_pkg, rrmh_ram and residual_running_mean_histogram_macros.svh.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------------
//  command  | start / busy                 | i_cmd i_element_index i_raw_value
//           |                              | i_normed_value
//  result   | o_strobe (one cycle)         | o_mean_raw o_mean_normed o_bin_index
//           |                              | o_bin_valid o_bin_count o_sample_number
//  config   | i_cfg_valid / o_cfg_ready    | i_cfg_index i_cfg_data
//
// An update item goes from accept to strobe through one mean RAM read,
// 33 steps of the two bit-serial dividers (mean delta / sample count), one
// read-modify-write step, one output register.
// Reset and the clear command both run a clearing pass over all ELEMENTS*BINS
// histogram entries (102400 at defaults), one entry per cycle; busy is high
// meanwhile. A clear item strobes its all-zero result at the pass end.
// The result side has no back-pressure; config is always ready.
`include "residual_running_mean_histogram_macros.svh"

module residual_running_mean_histogram #(
    parameter int ELEMENTS = rrmh_pkg::ELEMENTS_DEF,
    parameter int BINS     = rrmh_pkg::BINS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [9:0]  i_element_index,
    input  logic signed [31:0] i_raw_value,
    input  logic signed [31:0] i_normed_value,
    output logic        o_strobe,
    output logic signed [31:0] o_mean_raw,
    output logic signed [31:0] o_mean_normed,
    output logic [6:0]  o_bin_index,
    output logic        o_bin_valid,
    output logic [31:0] o_bin_count,
    output logic [31:0] o_sample_number,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int HDEPTH = ELEMENTS * BINS;
    localparam int MAW    = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int BW     = $clog2(BINS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    // divider sweeps 33 quotient bits
    localparam logic [5:0] DIV_LAST = 6'd32;

    localparam logic [31:0] CNT_MAX_L = rrmh_pkg::CNT_MAX;

    logic [2:0]  r_state;
    logic [HAW-1:0] r_clr;
    logic        r_emit;          // strobe a zero result when the pass ends
    logic [31:0] r_min;
    logic [30:0] r_scale;
    logic [31:0] r_count;

    logic [9:0]  r_idx;
    logic signed [31:0] r_raw, r_nrm;
    logic signed [63:0] r_prod;
    logic [BW-1:0] r_bin;
    logic        r_bvalid;
    logic [HAW-1:0] r_haddr;

    // bit-serial dividers, raw and normed lanes
    logic [5:0]  r_step;
    logic [31:0] r_div;
    logic [32:0] r_a_raw, r_a_nrm;
    logic [31:0] r_rem_raw, r_rem_nrm;
    logic [32:0] r_q_raw, r_q_nrm;
    logic        r_neg_raw, r_neg_nrm;
    logic [31:0] r_m_raw, r_m_nrm;

    logic        r_strobe;
    logic [31:0] r_o_raw, r_o_nrm, r_o_cnt, r_o_smp;
    logic [6:0]  r_o_bin;
    logic        r_o_bv;

    logic        accept;
    logic        idx_ok;
    logic [31:0] idx32;
    logic [63:0] mean_rdata, mean_wdata;
    logic        mean_we;
    logic [MAW-1:0] mean_waddr, mean_raddr;
    logic [31:0] hist_rdata, hist_wdata, hist_inc;
    logic        hist_we;
    logic [HAW-1:0] hist_waddr;

    logic signed [32:0] diff_raw, diff_nrm, t_val;
    logic [32:0] ds_raw, ds_nrm;
    logic [33:0] sum_raw, sum_nrm;
    logic [31:0] bin_hi, hmul;
    logic        b_valid;
    logic [BW-1:0] b_sel;
    logic [31:0] clr32;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nb,
                                             input logic [31:0] d);
        logic [32:0] sh;
        logic [32:0] sub;
        sh  = {rem, nb};
        sub = sh - {1'b0, d};
        if (sh >= {1'b0, d}) begin
            div_step = {1'b1, sub[31:0]};
        end else begin
            div_step = {1'b0, sh[31:0]};
        end
    endfunction

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign idx32       = {22'd0, r_idx};
    assign idx_ok      = (idx32 < 32'(ELEMENTS));
    assign clr32       = 32'(r_clr);

    // mean RAM: {normed, raw}
    assign mean_raddr = MAW'({22'd0, i_element_index});

    rrmh_ram #(.WIDTH(64), .DEPTH(ELEMENTS)) u_mean_ram (
        .i_clk   (i_clk),
        .i_we    (mean_we),
        .i_waddr (mean_waddr),
        .i_wdata (mean_wdata),
        .i_raddr (mean_raddr),
        .o_rdata (mean_rdata)
    );

    rrmh_ram #(.WIDTH(32), .DEPTH(HDEPTH)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (r_haddr),
        .o_rdata (hist_rdata)
    );

    // LOAD: deltas against the stored means, bin product
    always_comb begin
        diff_raw = {r_raw[31], r_raw} - {mean_rdata[31], mean_rdata[31:0]};
        diff_nrm = {r_nrm[31], r_nrm} - {mean_rdata[63], mean_rdata[63:32]};
        t_val    = {r_nrm[31], r_nrm} - {r_min[31], r_min};
    end

    // bin from the product: truncate toward zero, so anything above -2^32 is bin 0
    always_comb begin
        bin_hi  = r_prod[63:32];
        if (r_prod[63]) begin
            b_valid = (bin_hi == CNT_MAX_L) && (r_prod[31:0] != 32'd0);
            b_sel   = '0;
        end else begin
            b_valid = (bin_hi < 32'(BINS));
            b_sel   = bin_hi[BW-1:0];
        end
        hmul = idx32 * 32'(BINS) + 32'(b_sel);
    end

    // UPD: apply signed quotient, saturating bin increment
    always_comb begin
        ds_raw  = r_neg_raw ? (33'd0 - r_q_raw) : r_q_raw;
        ds_nrm  = r_neg_nrm ? (33'd0 - r_q_nrm) : r_q_nrm;
        sum_raw = {{2{r_m_raw[31]}}, r_m_raw} + {ds_raw[32], ds_raw};
        sum_nrm = {{2{r_m_nrm[31]}}, r_m_nrm} + {ds_nrm[32], ds_nrm};
        hist_inc = (hist_rdata == CNT_MAX_L) ? hist_rdata : hist_rdata + 32'd1;
    end

    always_comb begin
        if (r_state == S_CLR) begin
            mean_we    = (clr32 < 32'(ELEMENTS));
            mean_waddr = clr32[MAW-1:0];
            mean_wdata = '0;
            hist_we    = 1'b1;
            hist_waddr = r_clr;
            hist_wdata = '0;
        end else begin
            mean_we    = (r_state == S_UPD) && idx_ok;
            mean_waddr = idx32[MAW-1:0];
            mean_wdata = {sum_nrm[31:0], sum_raw[31:0]};
            hist_we    = (r_state == S_UPD) && idx_ok && r_bvalid;
            hist_waddr = r_haddr;
            hist_wdata = hist_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [32:0] st_raw;
        logic [32:0] st_nrm;
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_emit   <= 1'b0;
            r_min    <= rrmh_pkg::HIST_MIN_RST;
            r_scale  <= rrmh_pkg::HIST_SCALE_RST;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            st_raw = div_step(r_rem_raw, r_a_raw[32], r_div);
            st_nrm = div_step(r_rem_nrm, r_a_nrm[32], r_div);
            r_strobe <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    rrmh_pkg::REG_HIST_MIN:   r_min   <= i_cfg_data;
                    rrmh_pkg::REG_HIST_SCALE: r_scale <= i_cfg_data[30:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_idx <= i_element_index;
                        r_raw <= i_raw_value;
                        r_nrm <= i_normed_value;
                        if (i_cmd == rrmh_pkg::CMD_CLEAR) begin
                            r_count <= '0;
                            r_clr   <= '0;
                            r_emit  <= 1'b1;
                            r_state <= S_CLR;
                        end else begin
                            if (i_element_index == 10'd0 && r_count != CNT_MAX_L) begin
                                r_count <= r_count + 32'd1;
                            end
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_CLR: begin
                    if (clr32 == 32'(HDEPTH - 1)) begin
                        r_state <= S_IDLE;
                        if (r_emit) begin
                            r_strobe <= 1'b1;
                            r_o_raw  <= '0;
                            r_o_nrm  <= '0;
                            r_o_bin  <= '0;
                            r_o_bv   <= 1'b0;
                            r_o_cnt  <= '0;
                            r_o_smp  <= '0;
                        end
                        r_emit <= 1'b0;
                    end else begin
                        r_clr <= r_clr + HAW'(1);
                    end
                end
                S_LOAD: begin
                    r_m_raw   <= mean_rdata[31:0];
                    r_m_nrm   <= mean_rdata[63:32];
                    r_neg_raw <= diff_raw[32];
                    r_neg_nrm <= diff_nrm[32];
                    r_a_raw   <= diff_raw[32] ? 33'(-diff_raw) : 33'(diff_raw);
                    r_a_nrm   <= diff_nrm[32] ? 33'(-diff_nrm) : 33'(diff_nrm);
                    r_rem_raw <= '0;
                    r_rem_nrm <= '0;
                    r_div     <= (r_count == 32'd0) ? 32'd1 : r_count;
                    r_prod    <= 64'(t_val) * 64'($signed({1'b0, r_scale}));
                    r_step    <= '0;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_a_raw   <= {r_a_raw[31:0], 1'b0};
                    r_a_nrm   <= {r_a_nrm[31:0], 1'b0};
                    r_rem_raw <= st_raw[31:0];
                    r_rem_nrm <= st_nrm[31:0];
                    r_q_raw   <= {r_q_raw[31:0], st_raw[32]};
                    r_q_nrm   <= {r_q_nrm[31:0], st_nrm[32]};
                    r_bin     <= b_sel;
                    r_bvalid  <= b_valid;
                    r_haddr   <= hmul[HAW-1:0];
                    r_step    <= r_step + 6'd1;
                    if (r_step == DIV_LAST) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_strobe <= 1'b1;
                    r_o_smp  <= r_count;
                    r_o_raw  <= idx_ok ? sum_raw[31:0] : 32'd0;
                    r_o_nrm  <= idx_ok ? sum_nrm[31:0] : 32'd0;
                    r_o_bv   <= idx_ok && r_bvalid;
                    r_o_bin  <= (idx_ok && r_bvalid) ? 7'(32'(r_bin)) : 7'd0;
                    r_o_cnt  <= (idx_ok && r_bvalid) ? hist_inc : 32'd0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe        = r_strobe;
    assign o_mean_raw      = r_o_raw;
    assign o_mean_normed   = r_o_nrm;
    assign o_bin_index     = r_o_bin;
    assign o_bin_valid     = r_o_bv;
    assign o_bin_count     = r_o_cnt;
    assign o_sample_number = r_o_smp;

    `RRMH_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe, "strobe held")
    `RRMH_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "strobe while busy")
    `RRMH_ASSERT_NOW(a_bin_count, i_clk, i_rst_n, o_strobe && o_bin_valid, o_bin_count != 32'd0, "bin valid without count")
    `RRMH_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept not busy")
endmodule

/* hw/rtl/rrmh_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module rrmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
